// ===== sv/skvm_pkg.sv =====
`default_nettype none
package skvm_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int PAYLOAD_W    = 32;

  typedef struct packed {
    logic signed [KEY_W-1:0]     key;
    logic signed [PAYLOAD_W-1:0] payload;
  } pair_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;   // insert in_pair at its sorted place
    logic drain;  // shift one place toward cell 0
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/skvm_in_if.sv =====
`default_nettype none
interface skvm_in_if;
  import skvm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [KEY_W-1:0]     key;
  logic signed [PAYLOAD_W-1:0] payload;
  logic                        last;

  modport source (output valid, output key, output payload, output last, input ready);
  modport sink   (input valid, input key, input payload, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/skvm_out_if.sv =====
`default_nettype none
interface skvm_out_if;
  import skvm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [KEY_W-1:0]     sorted_key;
  logic signed [PAYLOAD_W-1:0] sorted_payload;
  logic                        last_out;
  logic                        dropped;

  modport source (output valid, output sorted_key, output sorted_payload,
                  output last_out, output dropped, input ready);
  modport sink   (input valid, input sorted_key, input sorted_payload,
                  input last_out, input dropped, output ready);
endinterface
`default_nettype wire

// ===== sv/skvm_cell.sv =====
`default_nettype none
module skvm_cell
  import skvm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire pair_t      in_pair,     // broadcast new pair
  input  wire pair_t      left_pair,
  input  wire logic       left_valid,
  input  wire logic       left_gt,
  input  wire pair_t      right_pair,
  input  wire logic       right_valid,
  output pair_t           pair,
  output logic            valid,
  output logic            gt           // new pair goes at or before this cell
);

  pair_t pair_r, pair_nxt;
  logic  valid_r, valid_nxt;

  // strict compare: equal keys stay behind earlier arrivals
  assign gt = !valid_r || (in_pair.key < pair_r.key);

  always_comb begin
    pair_nxt  = pair_r;
    valid_nxt = valid_r;
    if (ctrl.drain) begin
      pair_nxt  = right_pair;
      valid_nxt = right_valid;
    end else if (ctrl.load && gt) begin
      if (left_gt) begin
        pair_nxt  = left_pair;
        valid_nxt = left_valid;
      end else begin
        pair_nxt  = in_pair;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

  assign pair  = pair_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

// ===== sv/stable_key_value_merge_sorter_unit.sv =====
// channel   dir  handshake        payload
// in_ch     in   valid/ready      key, payload, last
// out_ch    out  valid/ready      sorted_key, sorted_payload, last_out, dropped
//
// Loading takes one request per cycle; each pair that finds room is inserted at its sorted
// place in the cell row in the same cycle, so no sort phase follows.
// After the closing request, the set drains from cell 0, one result per cycle
// while out_ch.ready is high. in_ch.ready is low during the drain.
// Reset (rst_n low, synchronous) empties all cells and clears the drop flag.
`default_nettype none
module stable_key_value_merge_sorter_unit
  import skvm_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  skvm_in_if.sink   in_ch,
  skvm_out_if.source out_ch
);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t state_r;
  logic   overflow_r;

  pair_t      cell_pair  [CAPACITY];
  logic       cell_valid [CAPACITY];
  logic       cell_gt    [CAPACITY];
  cell_ctrl_t ctrl;
  pair_t      new_pair;

  logic in_acc, out_acc, full;

  assign full    = cell_valid[CAPACITY-1];
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign new_pair.key     = in_ch.key;
  assign new_pair.payload = in_ch.payload;

  // a request arriving while the row is full is dropped
  assign ctrl.load  = in_acc && !full;
  assign ctrl.drain = out_acc;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      pair_t left_pair, right_pair;
      logic  left_valid, left_gt, right_valid;

      if (gi == 0) begin : g_head
        assign left_pair  = new_pair;
        assign left_valid = 1'b0;
        assign left_gt    = 1'b0;
      end else begin : g_mid
        assign left_pair  = cell_pair[gi-1];
        assign left_valid = cell_valid[gi-1];
        assign left_gt    = cell_gt[gi-1];
      end

      if (gi == CAPACITY-1) begin : g_tail
        assign right_pair  = new_pair;
        assign right_valid = 1'b0;
      end else begin : g_body
        assign right_pair  = cell_pair[gi+1];
        assign right_valid = cell_valid[gi+1];
      end

      skvm_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_pair     (new_pair),
        .left_pair   (left_pair),
        .left_valid  (left_valid),
        .left_gt     (left_gt),
        .right_pair  (right_pair),
        .right_valid (right_valid),
        .pair        (cell_pair[gi]),
        .valid       (cell_valid[gi]),
        .gt          (cell_gt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      overflow_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) overflow_r <= 1'b1;
            if (in_ch.last) state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_acc && out_ch.last_out) begin
            state_r    <= ST_LOAD;
            overflow_r <= 1'b0;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_LOAD);

  // a closing set always holds at least one pair, so cell 0 is valid here
  assign out_ch.valid          = (state_r == ST_DRAIN) && cell_valid[0];
  assign out_ch.sorted_key     = cell_pair[0].key;
  assign out_ch.sorted_payload = cell_pair[0].payload;
  assign out_ch.last_out       = !cell_valid[1];
  assign out_ch.dropped        = overflow_r;

endmodule
`default_nettype wire

// ===== test/stable_key_value_merge_sorter_unit_test.sv =====
module stable_key_value_merge_sorter_unit_test;
  import skvm_pkg::*;

  localparam int SET_CAPACITY = CAPACITY_DEF;
  localparam int ITEM_TARGET  = 350;
  localparam int IDLE_UNTIL   = 300;   // no new idling starts on either side past this many requests
  localparam int DRAIN_SLACK  = 16;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EXTREME} key_mode_t;

  typedef struct {
    pair_t pair;
    logic  last_out;
    logic  dropped;
  } sorted_result_t;

  // Tracks the set being loaded and the sorted results still owed by the block.
  class sort_order_board_t;
    pair_t          open_set[$];
    bit             set_overflowed;
    sorted_result_t owed_results[$];
    int             errors;

    function void note_request(pair_t pr, logic closes);
      pair_t          ordered[$];
      sorted_result_t res;
      int             pos;
      if (open_set.size() < SET_CAPACITY) open_set.insert(open_set.size(), pr);
      else set_overflowed = 1'b1;
      if (closes) begin
        // stable insertion: a pair goes after every earlier pair with key <= its key
        foreach (open_set[i]) begin
          pos = ordered.size();
          while (pos > 0 && $signed(ordered[pos-1].key) > $signed(open_set[i].key)) pos--;
          ordered.insert(pos, open_set[i]);
        end
        foreach (ordered[i]) begin
          res.pair     = ordered[i];
          res.last_out = (i == ordered.size() - 1);
          res.dropped  = set_overflowed;
          owed_results.insert(owed_results.size(), res);
        end
        open_set.delete();
        set_overflowed = 1'b0;
      end
    endfunction

    function void check_result(pair_t got, logic got_last, logic got_dropped);
      sorted_result_t exp;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: key %0d payload %0d", $time,
                 got.key, got.payload);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.key !== exp.pair.key) begin
        $display("%0t: sorted_key expected %0d actual %0d", $time, exp.pair.key, got.key);
        errors++;
      end
      if (got.payload !== exp.pair.payload) begin
        $display("%0t: sorted_payload expected %0d actual %0d", $time,
                 exp.pair.payload, got.payload);
        errors++;
      end
      if (got_last !== exp.last_out) begin
        $display("%0t: last_out expected %0b actual %0b", $time, exp.last_out, got_last);
        errors++;
      end
      if (got_dropped !== exp.dropped) begin
        $display("%0t: dropped expected %0b actual %0b", $time, exp.dropped, got_dropped);
        errors++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   items_sent = 0;
  int   cycle_count = 0;
  sort_order_board_t board = new();

  skvm_in_if  in_ch();
  skvm_out_if out_ch();

  stable_key_value_merge_sorter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: sample at the edge, then pick ready for the next cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result('{key: out_ch.sorted_key, payload: out_ch.sorted_payload},
                           out_ch.last_out, out_ch.dropped);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (items_sent < IDLE_UNTIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One request; returns at the edge where it was accepted, valid still high.
  task automatic send_pair(input logic signed [KEY_W-1:0] k,
                           input logic signed [PAYLOAD_W-1:0] p, input logic closes);
    if (items_sent < IDLE_UNTIL && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.key     <= k;
    in_ch.payload <= p;
    in_ch.last    <= closes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request('{key: k, payload: p}, closes);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key(key_mode_t mode);
    case (mode)
      KEYS_WIDE:      return $urandom;
      KEYS_CLUSTERED: return int'($urandom_range(0, 6)) - 3;   // lots of ties
      default: begin
        case ($urandom_range(0, 3))
          0:       return KEY_MIN;
          1:       return KEY_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int        tie_keys[5];
    int        set_no;
    int        set_len;
    key_mode_t mode;

    tie_keys      = '{5, 5, -3, 5, -3};
    in_ch.valid   = 1'b0;
    in_ch.key     = '0;
    in_ch.payload = '0;
    in_ch.last    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-pair set
    send_pair(KEY_MIN, KEY_MAX, 1'b1);
    // extremes of key and payload, signed order across zero
    send_pair(KEY_MAX, KEY_MIN, 1'b0);
    send_pair(KEY_MIN, 0, 1'b0);
    send_pair(0, -1, 1'b0);
    send_pair(-1, 1, 1'b0);
    send_pair(1, KEY_MAX, 1'b1);
    // equal keys must keep arrival order
    for (int i = 0; i < 5; i++) send_pair(tie_keys[i], i, i == 4);
    // reverse order input
    for (int i = 0; i < 4; i++) send_pair(4 - i, -i, i == 3);
    send_pair(KEY_MAX, KEY_MIN, 1'b1);

    // hold off until the block has handed back everything
    wait_drained();

    // random sets: mostly short, one exactly full, two overflowing
    // (each of them closed by a pair that itself gets dropped)
    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case (set_no)
        2:       set_len = SET_CAPACITY;
        5:       set_len = SET_CAPACITY + 1;
        8:       set_len = SET_CAPACITY + 6;
        default: set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                         : $urandom_range(1, 8);
      endcase
      mode = key_mode_t'($urandom_range(0, 2));
      for (int i = 0; i < set_len; i++)
        send_pair(pick_key(mode), pick_payload(), i == set_len - 1);
      set_no++;
    end

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
